// ===== rtl/core/cpts_pkg.sv =====
// Shared types, constants and helpers for the counter-priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package cpts_pkg;

  localparam int unsigned NUM_TASKS_DEF = 64;
  localparam logic [7:0]  INIT_SLICE    = 8'd10;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SCHED  = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  localparam logic [2:0] RS_RUNNING = 3'd0;

  typedef struct packed {
    logic [2:0] opcode;
    logic       user_mode;
    logic [5:0] slot;
    logic [7:0] priority_value;
    logic [2:0] state_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] current_task;
    logic       switched;
    logic [7:0] current_slice;
    logic       idle_fallback;
  } out_item_t;

  typedef struct packed {
    logic [2:0] state;
    logic [7:0] slice;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic ld_in;
    logic rd_op;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic reload;
    logic commit;
    logic rd_cur;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_sched;
    logic scan_done;
    logic found;
    logic out_free;
  } ctrl_status_t;

  // Value an entry holds before its first write.
  function automatic entry_t rst_entry(input logic is_task0);
    entry_t e;
    e.state = RS_RUNNING;
    e.slice = is_task0 ? INIT_SLICE : 8'd0;
    e.prio  = is_task0 ? INIT_SLICE : 8'd0;
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpts_ctrl.sv =====
// Sequencer for the scheduler: operation decode steps, up to two table scans, result handoff.
`timescale 1ns / 1ps
`default_nettype none

module cpts_ctrl import cpts_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t st_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD_OP  = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCAN1  = 7'b0001000,
    S_SCAN2  = 7'b0010000,
    S_FIN_RD = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_RD_OP;
        end
      end
      S_RD_OP: begin
        cmd_o.rd_op = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (st_i.need_sched) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN1;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_SCAN1: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) begin
          if (st_i.found) begin
            cmd_o.commit = 1'b1;
            state_d      = S_FIN_RD;
          end else begin
            // nothing runnable: second pass reloads counters while it picks
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.reload   = 1'b1;
        if (st_i.scan_done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpts_datapath.sv =====
// Task table memory, valid bits, scan unit, current task and result register.
`timescale 1ns / 1ps
`default_nettype none

module cpts_datapath import cpts_pkg::*; #(
  parameter int unsigned NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  ctrl_cmd_t    cmd_i,
  output ctrl_status_t st_o,
  input  in_item_t     in_data_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output out_item_t    out_data_o
);

  localparam int unsigned IW = $clog2(NUM_TASKS);
  localparam int unsigned CW = IW + 1;

  in_item_t              op_q;
  logic [IW-1:0]         before_q;
  logic [IW-1:0]         run_q, run_d;
  logic                  idle_q, idle_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  pv_q, pv_d;
  logic [7:0]            top_q, top_d;
  logic [IW-1:0]         best_q, best_d;
  logic [NUM_TASKS-1:0]  ev_q, ev_d;
  logic [NUM_TASKS-1:0]  init_q, init_d;

  entry_t                mem_q [NUM_TASKS];
  entry_t                rd_q;
  logic                  rd_init_q;
  logic [IW-1:0]         rd_addr_q;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  entry_t                wr_data;

  entry_t                ent;
  logic                  ent_valid;
  logic                  slot_ok;
  logic [IW-1:0]         slot_idx;
  logic                  issuing;
  logic [7:0]            slice_n;
  logic [7:0]            slice_dec;
  logic                  found;

  out_item_t             out_q;
  logic                  out_valid_q;

  assign slot_ok   = 32'(op_q.slot) < NUM_TASKS;
  assign slot_idx  = IW'(op_q.slot);
  assign issuing   = cmd_i.scan_run && (cnt_q < CW'(NUM_TASKS));
  assign ent       = rd_init_q ? rd_q : rst_entry(rd_addr_q == '0);
  assign ent_valid = ev_q[rd_addr_q];
  assign slice_dec = ent.slice - 8'd1;
  assign found     = top_q != 8'd0;
  // pass two sees the reloaded counter of a valid task
  assign slice_n   = (cmd_i.reload && ent_valid) ? ent.prio : ent.slice;

  // read port
  always_comb begin
    rd_en   = cmd_i.rd_op || cmd_i.rd_cur || issuing;
    rd_addr = run_q;
    if (cmd_i.rd_op && op_q.opcode != OP_TICK) begin
      rd_addr = slot_idx;
    end else if (issuing) begin
      rd_addr = cnt_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q      <= mem_q[rd_addr];
      rd_init_q <= init_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // write port, valid bits, scan tracking
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = ent;
    ev_d    = ev_q;
    cnt_d   = cnt_q;
    pv_d    = pv_q;
    top_d   = top_q;
    best_d  = best_q;
    run_d   = run_q;
    idle_d  = idle_q;

    if (cmd_i.ld_in) begin
      idle_d = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (op_q.opcode)
        OP_TICK: begin
          if (ent.slice != 8'd0) begin
            wr_en         = 1'b1;
            wr_data.slice = (slice_dec == 8'd0 && !op_q.user_mode) ? 8'd1 : slice_dec;
          end
        end
        OP_ADD: begin
          if (slot_ok) begin
            wr_en          = 1'b1;
            wr_data.state  = RS_RUNNING;
            wr_data.slice  = op_q.priority_value;
            wr_data.prio   = op_q.priority_value;
            ev_d[slot_idx] = 1'b1;
          end
        end
        OP_SET: begin
          if (slot_ok) begin
            wr_en         = 1'b1;
            wr_data.state = op_q.state_value;
          end
        end
        OP_REMOVE: begin
          if (slot_ok) begin
            wr_en          = 1'b1;
            wr_data        = '0;
            ev_d[slot_idx] = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.scan_run) begin
      cnt_d = issuing ? cnt_q + CW'(1) : cnt_q;
      pv_d  = issuing;
      if (pv_q && ent_valid) begin
        if (cmd_i.reload) begin
          wr_en         = 1'b1;
          wr_data.slice = ent.prio;
        end
        if (ent.state == RS_RUNNING && slice_n > top_q) begin
          top_d  = slice_n;
          best_d = rd_addr_q;
        end
      end
    end

    if (cmd_i.scan_start) begin
      cnt_d  = '0;
      pv_d   = 1'b0;
      top_d  = 8'd0;
      best_d = '0;
    end

    if (cmd_i.commit) begin
      run_d  = found ? best_q : '0;
      idle_d = !found;
    end
  end

  always_comb begin
    init_d = init_q;
    if (wr_en) begin
      init_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q   <= NUM_TASKS'(1);
      init_q <= '0;
      run_q  <= '0;
      idle_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      top_q  <= 8'd0;
      best_q <= '0;
    end else begin
      ev_q   <= ev_d;
      init_q <= init_d;
      run_q  <= run_d;
      idle_q <= idle_d;
      cnt_q  <= cnt_d;
      pv_q   <= pv_d;
      top_q  <= top_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q     <= in_data_i;
      before_q <= run_q;
    end
    if (cmd_i.out_load) begin
      out_q.current_task  <= 6'(run_q);
      out_q.switched      <= run_q != before_q;
      out_q.current_slice <= ent.slice;
      out_q.idle_fallback <= idle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign st_o.need_sched = (op_q.opcode == OP_SCHED) ||
                           (op_q.opcode == OP_TICK && ent.slice == 8'd1 && op_q.user_mode);
  assign st_o.scan_done  = cnt_q == CW'(NUM_TASKS) && !pv_q;
  assign st_o.found      = found;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/counter_priority_task_scheduler.sv =====
// Flow: after a transfer, RD_OP reads the table, EXEC applies the operation, FIN_RD reads the
// current task and FIN loads the result register. A schedule (or a tick that expires in user
// mode) adds one table scan after EXEC, and a second reloading scan when nothing is runnable.
// One item in flight: the next is taken once the result is loaded, later while a result waits.
// Reset: task 0 valid with priority and slice 10, all else clear; the table needs no clear pass.
// Top level of the counter-priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

module counter_priority_task_scheduler import cpts_pkg::*; #(
  parameter int unsigned NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  cpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cpts_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("scheduler accepted back-to-back items");

  a_read_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd_op, cmd.rd_cur, cmd.scan_run}))
    else $error("table read port driven by two sources");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_fallback_task0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.idle_fallback |-> out_data_o.current_task == 6'd0)
    else $error("idle fallback reported with nonzero task");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the counter-priority task scheduler.
`timescale 1ns / 1ps

module testbench;
  import cpts_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam logic [2:0] RS_INTR    = 3'd1;
  localparam logic [2:0] RS_STOPPED = 3'd4;
  localparam logic [2:0] RS_ODD     = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 540;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned BURST_LO     = 300;
  localparam int unsigned BURST_HI     = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_TASKS_DEF + 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_ready = 1'b0;
  wire       in_ready;
  wire       out_valid;
  out_item_t out_data;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  bit          in_taken = 1'b0;
  bit          hold_out = 1'b0;
  bit          no_gaps = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;

  // Scheduler state as the testbench sees it
  logic       m_live   [NUM_TASKS_DEF];
  logic [2:0] m_rstate [NUM_TASKS_DEF];
  logic [7:0] m_count  [NUM_TASKS_DEF];
  logic [7:0] m_prio   [NUM_TASKS_DEF];
  logic [5:0] m_cur;

  counter_priority_task_scheduler DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ERROR: %s", $time, what);
    err_cnt++;
  endtask

  // Highest nonzero counter among live running tasks, lowest index on ties.
  function automatic bit find_top(output logic [5:0] idx);
    logic [7:0] top;
    top = '0;
    idx = '0;
    for (int i = 0; i < NUM_TASKS_DEF; i++) begin
      if (m_live[i] && m_rstate[i] == RS_RUNNING && m_count[i] > top) begin
        top = m_count[i];
        idx = i[5:0];
      end
    end
    return top != '0;
  endfunction

  // Returns 1 when nothing was runnable and task 0 was forced.
  function automatic bit reschedule();
    logic [5:0] pick;
    if (find_top(pick)) begin
      m_cur = pick;
      return 1'b0;
    end
    for (int i = 0; i < NUM_TASKS_DEF; i++) begin
      if (m_live[i]) m_count[i] = m_prio[i];
    end
    if (find_top(pick)) begin
      m_cur = pick;
      return 1'b0;
    end
    m_cur = '0;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_outcome(input in_item_t it);
    out_item_t  res;
    logic [5:0] prev_cur;
    logic [5:0] cur;
    logic       fallback;
    prev_cur = m_cur;
    cur      = m_cur;
    fallback = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        // an exhausted counter stays at zero and never triggers a reschedule
        if (m_count[cur] != '0) begin
          m_count[cur] = m_count[cur] - 8'd1;
          if (m_count[cur] == '0) begin
            if (it.user_mode) fallback = reschedule();
            else m_count[cur] = 8'd1;
          end
        end
      end
      OP_SCHED: fallback = reschedule();
      OP_ADD: begin
        m_live[it.slot]   = 1'b1;
        m_rstate[it.slot] = RS_RUNNING;
        m_prio[it.slot]   = it.priority_value;
        m_count[it.slot]  = it.priority_value;
      end
      OP_SET: m_rstate[it.slot] = it.state_value;
      OP_REMOVE: begin
        m_live[it.slot]   = 1'b0;
        m_rstate[it.slot] = RS_RUNNING;
        m_prio[it.slot]   = '0;
        m_count[it.slot]  = '0;
      end
      default: ;
    endcase
    res.current_task  = m_cur;
    res.switched      = (m_cur != prev_cur);
    res.current_slice = m_count[m_cur];
    res.idle_fallback = fallback;
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] op, input logic um,
                                         input logic [5:0] sl, input logic [7:0] pr,
                                         input logic [2:0] st);
    in_item_t it;
    it.opcode         = op;
    it.user_mode      = um;
    it.slot           = sl;
    it.priority_value = pr;
    it.state_value    = st;
    return it;
  endfunction

  function automatic in_item_t random_item(input logic [2:0] op);
    in_item_t    it;
    int unsigned r;
    it.opcode    = op;
    it.user_mode = 1'($urandom_range(1));
    it.slot      = ($urandom_range(99) < 75) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    r = $urandom_range(99);
    if (r < 10) it.priority_value = 8'($urandom_range(255));
    else if (r < 15) it.priority_value = '0;
    else it.priority_value = 8'($urandom_range(12, 1));
    it.state_value = ($urandom_range(99) < 55) ? RS_RUNNING : 3'($urandom_range(7));
    return it;
  endfunction

  // Input side: predict on every transfer.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      expected_q.push_back(predict_outcome(in_data));
      accepted_cnt++;
      in_taken = 1'b1;
    end
    no_gaps = (accepted_cnt >= BURST_LO) && (accepted_cnt < BURST_HI);
  end

  // Driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_q.size() > 0 && (no_gaps || $urandom_range(99) >= 31)) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_out && (no_gaps || $urandom_range(99) >= 31);
  end

  // Monitor
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result task=%0d", out_data.current_task));
      end else begin
        want = expected_q.pop_front();
        if (out_data.current_task !== want.current_task ||
            out_data.switched !== want.switched ||
            out_data.current_slice !== want.current_slice ||
            out_data.idle_fallback !== want.idle_fallback) begin
          report_mismatch($sformatf(
            "task %0d/%0d switched %0b/%0b slice %0d/%0d idle %0b/%0b (got/want)",
            out_data.current_task, want.current_task, out_data.switched, want.switched,
            out_data.current_slice, want.current_slice,
            out_data.idle_fallback, want.idle_fallback));
        end
      end
    end
  end

  // Long receiver stall so the block backs up into its input
  initial begin
    while (accepted_cnt < HOLD_AT) @(posedge clk);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    int unsigned real_cnt;
    int unsigned roll;
    int unsigned burst;
    for (int i = 0; i < NUM_TASKS_DEF; i++) begin
      m_live[i]   = (i == 0);
      m_rstate[i] = RS_RUNNING;
      m_count[i]  = (i == 0) ? INIT_SLICE : 8'd0;
      m_prio[i]   = (i == 0) ? INIT_SLICE : 8'd0;
    end
    m_cur = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_ADD, 1'b0, 6'd63, 8'd255, RS_RUNNING));
    pending_q.push_back(make_item(OP_ADD, 1'b0, 6'd1, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b1, 6'd0, 8'd0, RS_RUNNING));
    // odd state codes park a task without removing it
    pending_q.push_back(make_item(OP_SET, 1'b0, 6'd63, 8'd0, RS_ODD));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_UNUSED_LO, 1'b1, 6'd63, 8'd255, RS_ODD));
    pending_q.push_back(make_item(OP_UNUSED_HI, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    // current task removed: slice shows zero, ticks leave it there
    pending_q.push_back(make_item(OP_REMOVE, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b1, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_SET, 1'b0, 6'd5, 8'd0, RS_INTR));
    // nothing runnable: falls back to task 0
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_ADD, 1'b0, 6'd2, 8'd1, RS_RUNNING));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b1, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_ADD, 1'b0, 6'd3, 8'd200, RS_RUNNING));
    pending_q.push_back(make_item(OP_ADD, 1'b0, 6'd2, 8'd200, RS_RUNNING));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_SET, 1'b0, 6'd63, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_REMOVE, 1'b0, 6'd63, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_TICK, 1'b0, 6'd0, 8'd0, RS_RUNNING));
    pending_q.push_back(make_item(OP_SET, 1'b0, 6'd3, 8'd0, RS_STOPPED));
    pending_q.push_back(make_item(OP_SCHED, 1'b0, 6'd0, 8'd0, RS_RUNNING));

    real_cnt = 0;
    while (real_cnt < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 34) begin
        // runs of ticks let slices expire
        burst = $urandom_range(6, 1);
        repeat (burst) pending_q.push_back(random_item(OP_TICK));
        real_cnt += burst;
      end else begin
        if (roll < 50) pending_q.push_back(random_item(OP_SCHED));
        else if (roll < 70) pending_q.push_back(random_item(OP_ADD));
        else if (roll < 84) pending_q.push_back(random_item(OP_SET));
        else if (roll < 94) pending_q.push_back(random_item(OP_REMOVE));
        else pending_q.push_back(random_item(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))));
        if (roll < 94) real_cnt++;
      end
    end

    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cpts_pkg.sv
rtl/core/cpts_ctrl.sv
rtl/core/cpts_datapath.sv
rtl/core/counter_priority_task_scheduler.sv
tb/testbench.sv
